// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the cyclic prefix inserter.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OCPS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OCPS_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define OCPS_ASSERT(lbl, clk, rstn, prop, msg)
`define OCPS_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/ocps_pkg.sv =====
// Shared constants, types and codes of the cyclic prefix inserter.
// No dependencies.
`default_nettype none
package ocps_pkg;
	localparam int FFT_LEN    = 64;
	localparam int MAX_CP     = 16;
	localparam int SYNC_DEPTH = 1024;
	localparam int FFT_AW  = $clog2(FFT_LEN);
	localparam int SYM_AW  = FFT_AW + 1;
	localparam int SYNC_AW = $clog2(SYNC_DEPTH);
	localparam int SPOS_W  = SYNC_AW + 1;
	localparam int RAMP_N  = MAX_CP - 1;
	localparam int RAMP_AW = (RAMP_N > 1) ? $clog2(RAMP_N) : 1;
	localparam int POS_W   = $clog2(FFT_LEN + MAX_CP);
	localparam int LEN_W   = $clog2(FFT_LEN + MAX_CP + 1);
	localparam logic signed [15:0] SYNC_GAIN = 16'sd10355;
	localparam logic [15:0] COEF_ONE = 16'd32768;

	typedef enum logic [1:0] {OP_PUSH, OP_PULL, OP_SYNC, OP_RAMP} op_t;
	typedef enum logic [1:0] {REG_CP_LEN, REG_ROLLOFF, REG_SYNC_SYM, REG_PACKET} reg_idx_t;
	typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_RAMP, ST_TAIL, ST_OUT} back_state_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               eop;
		logic [9:0]         idx;
		logic               idx_ok;
		logic [15:0]        coef;
	} item_t;

	typedef struct packed {
		logic [4:0] cp_len;
		logic [4:0] win_len;
		logic [3:0] sync_symbols;
		logic       packet_mode;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ofdm_cyclic_prefix_sync_overlay.sv =====
// Top level: configuration registers, front queue and back execution unit.
// Uses ocps_pkg, ocps_front, ocps_back and assert_macros.svh.
//
// channel | dir | tdata                                  | tuser            | tlast
// s_*     | in  | re[15:0] im[31:16] idx[41:32] coef[57:42] | op[1:0]        | end_of_packet
// m_*     | out | out_re[15:0] out_im[31:16]             | out_valid, accepted | last_of_symbol
//
// A push or load passes the idle and output states of the back unit; a pull that reads
// a sample also passes the sum state, and in the window the ramp and tail states, set by
// the registered reads of the symbol, sync and ramp RAMs. The output register is loaded
// in the output state once it is free. Items are handled one at a time.
// Reset is asynchronous; the tail line clears at once, the RAMs hold garbage.
// The two-deep queue keeps accepting while the output register is stalled, until it is full.
`default_nettype none
`include "assert_macros.svh"
module ofdm_cyclic_prefix_sync_overlay import ocps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // sample_re, sample_im, table_index, flank_coef
	input  wire logic [1:0]  s_tuser,  // op
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_re, out_im
	output logic [1:0]       m_tuser,  // out_valid, accepted
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [4:0]  cfg_data
);
	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cp_len       <= 5'd16;
			cfg_q.win_len      <= 5'd0;
			cfg_q.sync_symbols <= 4'd1;
			cfg_q.packet_mode  <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_CP_LEN:   cfg_q.cp_len       <= cfg_data;
				REG_ROLLOFF:  cfg_q.win_len      <= cfg_data;
				REG_SYNC_SYM: cfg_q.sync_symbols <= cfg_data[3:0];
				REG_PACKET:   cfg_q.packet_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ocps_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	ocps_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	`OCPS_ASSERT(a_valid_acc, clk, arst_n, m_tvalid && m_tuser[0] |-> m_tuser[1], "no accept")
	`OCPS_ASSERT(a_last_valid, clk, arst_n, m_tvalid && m_tlast |-> m_tuser[0], "empty last")
	`OCPS_NEVER(a_empty_zero, clk, arst_n, m_tvalid && !m_tuser[0] && m_tdata != 32'd0, "data")
endmodule
`default_nettype wire

// ===== hw/rtl/ocps_ram.sv =====
// Generic simple dual-port RAM, registered read.
// No dependencies.
`default_nettype none
module ocps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ocps_front.sv =====
// Front end: takes input transactions, classifies them, queues two deep.
// Uses ocps_pkg.
`default_nettype none
module ocps_front import ocps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tlast,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);
	item_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      item;
	logic       push;

	always_comb begin
		item.op     = op_t'(s_tuser);
		item.re     = s_tdata[15:0];
		item.im     = s_tdata[31:16];
		item.idx    = s_tdata[41:32];
		item.eop    = s_tlast;
		item.coef   = (s_tdata[57:42] > COEF_ONE) ? COEF_ONE : s_tdata[57:42];
		case (item.op)
			OP_SYNC: item.idx_ok = int'(item.idx) < SYNC_DEPTH;
			OP_RAMP: item.idx_ok = int'(item.idx) < RAMP_N;
			default: item.idx_ok = 1'b0;
		endcase
	end

	assign s_tready = cnt_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ocps_back.sv =====
// Back end: executes queued transactions on the symbol, sync and ramp stores.
// Uses ocps_pkg and ocps_ram; holds the output register.
`default_nettype none
module ocps_back import ocps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	back_state_t state_q, state_d;

	logic [1:0]         buf_full_q, flush_pend_q;
	logic               wsel_q, rsel_q, base_q;
	logic [FFT_AW-1:0]  wp_q;
	logic [POS_W-1:0]   rp_q, p_q;
	logic [SPOS_W-1:0]  spos_q;
	logic [4:0]         cur_cp_q, cur_nwin_q, nwin_q;
	logic               win_q;
	logic               flushing_q;
	logic [RAMP_AW-1:0] fidx_q;
	logic [4:0]         flen_q;
	logic signed [15:0] tail_re_q [RAMP_N];
	logic signed [15:0] tail_im_q [RAMP_N];
	logic signed [16:0] s_re_q, s_im_q;
	logic signed [33:0] prod_re_q, prod_im_q;
	logic signed [19:0] acc_re_q, acc_im_q;
	logic               res_ov_q, res_acc_q, res_last_q;

	logic [31:0]        sym_rdata, sync_rdata;
	logic [15:0]        ramp_rdata;
	logic [SYM_AW-1:0]  sym_raddr;
	logic [RAMP_AW-1:0] ramp_raddr;

	// pull address generation
	logic [4:0]         eff_cp, r_cl, eff_nwin, cp_use, nwin_use;
	logic [LEN_W-1:0]   len;
	logic [FFT_AW-1:0]  si;
	logic [SPOS_W-1:0]  spos_w;
	logic               is_last, pull_ok, out_free;
	logic               pop_ov, pop_acc, pop_last;

	always_comb begin
		eff_cp = cfg.cp_len;
		if (int'(eff_cp) > MAX_CP) eff_cp = 5'(MAX_CP);
		if (int'(eff_cp) > FFT_LEN) eff_cp = 5'(FFT_LEN);
		r_cl = (cfg.win_len > eff_cp) ? eff_cp : cfg.win_len;
		eff_nwin = (r_cl > 5'd1) ? r_cl - 5'd1 : 5'd0;
		cp_use   = (rp_q == '0) ? eff_cp : cur_cp_q;
		nwin_use = (rp_q == '0) ? eff_nwin : cur_nwin_q;
		len = LEN_W'(FFT_LEN) + LEN_W'(cp_use);
		if (int'(rp_q) < int'(cp_use)) begin
			si = FFT_AW'(FFT_LEN - int'(cp_use) + int'(rp_q));
		end else begin
			si = FFT_AW'(int'(rp_q) - int'(cp_use));
		end
		if (int'(spos_q) >= int'(cfg.sync_symbols) * int'(len) || int'(spos_q) >= SYNC_DEPTH)
			spos_w = '0;
		else
			spos_w = spos_q;
		is_last = int'(rp_q) + 1 >= int'(len);
		pull_ok = buf_full_q[rsel_q];
	end

	// result flags of the transaction being popped
	always_comb begin
		pop_ov   = 1'b0;
		pop_acc  = 1'b0;
		pop_last = 1'b0;
		case (q_item.op)
			OP_PUSH: pop_acc = !buf_full_q[wsel_q];
			OP_SYNC, OP_RAMP: pop_acc = q_item.idx_ok;
			OP_PULL: begin
				pop_ov   = flushing_q || pull_ok;
				pop_acc  = flushing_q || pull_ok;
				pop_last = flushing_q ? (int'(fidx_q) + 1 >= int'(flen_q))
				                      : (pull_ok && is_last);
			end
			default: ;
		endcase
	end

	assign sym_raddr  = (state_q == ST_RAMP) ? {base_q, p_q[FFT_AW-1:0]} : {rsel_q, si};
	assign ramp_raddr = (state_q == ST_RAMP) ? RAMP_AW'(nwin_q - 5'd1 - 5'(p_q))
	                                         : p_q[RAMP_AW-1:0];
	assign q_pop    = q_valid && (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	ocps_ram #(.WIDTH(32), .DEPTH(2 * FFT_LEN)) u_sym (
		.clk(clk), .we(q_pop && q_item.op == OP_PUSH && !buf_full_q[wsel_q]),
		.waddr({wsel_q, wp_q}), .wdata({q_item.im, q_item.re}),
		.raddr(sym_raddr), .rdata(sym_rdata)
	);
	ocps_ram #(.WIDTH(32), .DEPTH(SYNC_DEPTH)) u_sync (
		.clk(clk), .we(q_pop && q_item.op == OP_SYNC && q_item.idx_ok),
		.waddr(q_item.idx[SYNC_AW-1:0]), .wdata({q_item.im, q_item.re}),
		.raddr(spos_w[SYNC_AW-1:0]), .rdata(sync_rdata)
	);
	ocps_ram #(.WIDTH(16), .DEPTH(RAMP_N)) u_ramp (
		.clk(clk), .we(q_pop && q_item.op == OP_RAMP && q_item.idx_ok),
		.waddr(q_item.idx[RAMP_AW-1:0]), .wdata(q_item.coef),
		.raddr(ramp_raddr), .rdata(ramp_rdata)
	);

	function automatic logic [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) return 16'h7fff;
		if (v < -20'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	// datapath terms
	logic signed [30:0] sync_p_re, sync_p_im;
	logic signed [16:0] s_re, s_im;
	logic signed [33:0] tl_p_re, tl_p_im;
	logic signed [33:0] pr_re, pr_im;

	always_comb begin
		sync_p_re = 31'(signed'(sync_rdata[15:0]) * SYNC_GAIN) + 31'sd16384;
		sync_p_im = 31'(signed'(sync_rdata[31:16]) * SYNC_GAIN) + 31'sd16384;
		s_re = 17'(signed'(sym_rdata[15:0])) + 17'(sync_p_re >>> 15);
		s_im = 17'(signed'(sym_rdata[31:16])) + 17'(sync_p_im >>> 15);
		tl_p_re = 34'(signed'(sym_rdata[15:0]) * signed'({1'b0, ramp_rdata})) + 34'sd16384;
		tl_p_im = 34'(signed'(sym_rdata[31:16]) * signed'({1'b0, ramp_rdata})) + 34'sd16384;
		pr_re = prod_re_q + 34'sd16384;
		pr_im = prod_im_q + 34'sd16384;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = (q_item.op == OP_PULL && !flushing_q && pull_ok)
				? ST_SUM : ST_OUT;
			ST_SUM:  state_d = win_q ? ST_RAMP : ST_OUT;
			ST_RAMP: state_d = ST_TAIL;
			ST_TAIL: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SUM: begin
				s_re_q <= s_re;
				s_im_q <= s_im;
				acc_re_q <= 20'(s_re);
				acc_im_q <= 20'(s_im);
			end
			ST_RAMP: begin
				prod_re_q <= 34'(s_re_q * signed'({1'b0, ramp_rdata}));
				prod_im_q <= 34'(s_im_q * signed'({1'b0, ramp_rdata}));
			end
			ST_TAIL: begin
				acc_re_q <= 20'(19'(pr_re >>> 15)) + 20'(tail_re_q[p_q[RAMP_AW-1:0]]);
				acc_im_q <= 20'(19'(pr_im >>> 15)) + 20'(tail_im_q[p_q[RAMP_AW-1:0]]);
			end
			ST_IDLE: begin
				acc_re_q <= 20'(tail_re_q[fidx_q]);
				acc_im_q <= 20'(tail_im_q[fidx_q]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_full_q   <= '0;
			flush_pend_q <= '0;
			wsel_q       <= 1'b0;
			rsel_q       <= 1'b0;
			base_q       <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
			p_q          <= '0;
			spos_q       <= '0;
			cur_cp_q     <= '0;
			cur_nwin_q   <= '0;
			nwin_q       <= '0;
			win_q        <= 1'b0;
			flushing_q   <= 1'b0;
			fidx_q       <= '0;
			flen_q       <= '0;
			res_ov_q     <= 1'b0;
			res_acc_q    <= 1'b0;
			res_last_q   <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			m_tlast      <= 1'b0;
			for (int i = 0; i < RAMP_N; i++) begin
				tail_re_q[i] <= '0;
				tail_im_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				res_ov_q   <= pop_ov;
				res_acc_q  <= pop_acc;
				res_last_q <= pop_last;
				case (q_item.op)
					OP_PUSH: if (!buf_full_q[wsel_q]) begin
						if (int'(wp_q) + 1 >= FFT_LEN) begin
							buf_full_q[wsel_q]   <= 1'b1;
							flush_pend_q[wsel_q] <= q_item.eop;
							wp_q   <= '0;
							wsel_q <= !wsel_q;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
					OP_PULL: if (flushing_q) begin
						fidx_q    <= fidx_q + 1'b1;
						if (int'(fidx_q) + 1 >= int'(flen_q)) begin
							// last flushed sample: clear the tail line
							flushing_q <= 1'b0;
							for (int i = 0; i < RAMP_N; i++) begin
								tail_re_q[i] <= '0;
								tail_im_q[i] <= '0;
							end
						end
					end else if (pull_ok) begin
						cur_cp_q   <= cp_use;
						cur_nwin_q <= nwin_use;
						nwin_q     <= nwin_use;
						p_q        <= rp_q;
						win_q      <= int'(rp_q) < int'(nwin_use);
						base_q     <= rsel_q;
						spos_q     <= spos_w + 1'b1;
						if (is_last) begin
							rp_q <= '0;
							buf_full_q[rsel_q]   <= 1'b0;
							flush_pend_q[rsel_q] <= 1'b0;
							if (cfg.packet_mode && flush_pend_q[rsel_q] && nwin_use != 5'd0) begin
								flushing_q <= 1'b1;
								fidx_q     <= '0;
								flen_q     <= nwin_use;
							end
							rsel_q <= !rsel_q;
						end else begin
							rp_q <= rp_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_TAIL) begin
				// refill the tail line with the reversed ramp
				tail_re_q[p_q[RAMP_AW-1:0]] <= 16'(tl_p_re >>> 15);
				tail_im_q[p_q[RAMP_AW-1:0]] <= 16'(tl_p_im >>> 15);
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid <= 1'b1;
				m_tdata  <= res_ov_q ? {sat16(acc_im_q), sat16(acc_re_q)} : 32'd0;
				m_tuser  <= {res_acc_q, res_ov_q};
				m_tlast  <= res_last_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the OFDM cyclic prefix inserter with sync overlay.
// Drives the stream and config ports, predicts every output transaction in SV,
// and compares them in order. Needs ocps_pkg and ofdm_cyclic_prefix_sync_overlay.
`timescale 1ns / 100ps
module tb;
	import ocps_pkg::*;

	typedef struct packed {
		logic               vld;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
		logic               acc;
	} sample_res_t;

	typedef struct {
		op_t         op;
		logic [15:0] re;
		logic [15:0] im;
		logic        eop;
		logic [9:0]  idx;
		logic [15:0] coef;
		int          reps;
		bit          typed;
		sample_res_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // re, im, idx, coef, zero pad
	logic [1:0]  s_tuser;  // op
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // out_re, out_im
	logic [1:0]  m_tuser;  // out_valid, accepted
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [4:0]  cfg_data;

	ofdm_cyclic_prefix_sync_overlay dut (.*);

	// predictor state
	logic signed [15:0] sym_re [2*FFT_LEN];
	logic signed [15:0] sym_im [2*FFT_LEN];
	logic signed [15:0] sync_re [SYNC_DEPTH];
	logic signed [15:0] sync_im [SYNC_DEPTH];
	longint ramp [MAX_CP];
	longint tail_re [MAX_CP];
	longint tail_im [MAX_CP];
	int sync_pos, wr_pos, rd_pos, wsel, rsel, sym_cp, sym_nwin, flush_idx, flush_len;
	bit [1:0] full, flush_pend;
	bit flushing;
	int cfg_cp = 16, cfg_roll = 0, cfg_sync = 1, cfg_pkt = 0;

	sample_res_t expected_q [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit idle_on = 1;
	bit hold_req = 0;
	stim_row_t dir_tab [$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_q15(longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic sample_res_t predict_sample(op_t op, logic signed [15:0] re,
			logic signed [15:0] im, logic eop, logic [9:0] idx, logic [15:0] coef);
		sample_res_t r;
		int p, len, si, base, lim, rl;
		longint sr, sm, up, dn;
		r = '0;
		case (op)
			OP_PUSH: if (!full[wsel]) begin
				sym_re[wsel*FFT_LEN + wr_pos] = re;
				sym_im[wsel*FFT_LEN + wr_pos] = im;
				r.acc = 1;
				if (wr_pos + 1 >= FFT_LEN) begin
					full[wsel] = 1;
					flush_pend[wsel] = eop;
					wr_pos = 0;
					wsel ^= 1;
				end else begin
					wr_pos++;
				end
			end
			OP_SYNC: begin
				sync_re[idx] = re;
				sync_im[idx] = im;
				r.acc = 1;
			end
			OP_RAMP: if (idx < MAX_CP - 1) begin
				ramp[idx] = (coef > 16'd32768) ? 32768 : coef;
				r.acc = 1;
			end
			default: if (flushing) begin
				r.re = sat16(tail_re[flush_idx]);
				r.im = sat16(tail_im[flush_idx]);
				r.vld = 1;
				r.acc = 1;
				flush_idx++;
				if (flush_idx >= flush_len) begin
					r.last = 1;
					flushing = 0;
					foreach (tail_re[i]) begin
						tail_re[i] = 0;
						tail_im[i] = 0;
					end
				end
			end else if (full[rsel]) begin
				base = rsel * FFT_LEN;
				if (rd_pos == 0) begin
					sym_cp = (cfg_cp > MAX_CP) ? MAX_CP : cfg_cp;
					rl = (cfg_roll > sym_cp) ? sym_cp : cfg_roll;
					sym_nwin = (rl > 1) ? rl - 1 : 0;
				end
				p = rd_pos;
				len = FFT_LEN + sym_cp;
				si = (p < sym_cp) ? FFT_LEN - sym_cp + p : p - sym_cp;
				sr = sym_re[base + si];
				sm = sym_im[base + si];
				lim = cfg_sync * len;
				if (sync_pos >= lim || sync_pos >= SYNC_DEPTH) sync_pos = 0;
				sr += round_q15(longint'(sync_re[sync_pos]) * 10355);
				sm += round_q15(longint'(sync_im[sync_pos]) * 10355);
				sync_pos++;
				if (p < sym_nwin) begin
					up = ramp[p];
					dn = ramp[sym_nwin - 1 - p];
					sr = round_q15(sr * up) + tail_re[p];
					sm = round_q15(sm * up) + tail_im[p];
					tail_re[p] = round_q15(longint'(sym_re[base + p]) * dn);
					tail_im[p] = round_q15(longint'(sym_im[base + p]) * dn);
				end
				r.re = sat16(sr);
				r.im = sat16(sm);
				r.vld = 1;
				r.acc = 1;
				if (p + 1 >= len) begin
					r.last = 1;
					rd_pos = 0;
					full[rsel] = 0;
					if (cfg_pkt != 0 && flush_pend[rsel] && sym_nwin > 0) begin
						flushing = 1;
						flush_idx = 0;
						flush_len = sym_nwin;
					end
					flush_pend[rsel] = 0;
					rsel ^= 1;
				end else begin
					rd_pos++;
				end
			end
		endcase
		return r;
	endfunction

	// Offer one transaction; returns the predicted result once it is taken.
	task automatic send_item(op_t op, logic [15:0] re, logic [15:0] im, logic eop,
			logic [9:0] idx, logic [15:0] coef, output sample_res_t r);
		while (idle_on && $urandom_range(99) < 33) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = op;
		s_tlast = eop;
		s_tdata = {6'b0, coef, idx, im, re};
		do @(posedge clk); while (!s_tready);
		r = predict_sample(op, re, im, eop, idx, coef);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain_outputs();
		while (expected_q.size() != 0) @(negedge clk);
		// let an ignored push or failed load finish in the back unit
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t a, int v);
		cfg_we = 1;
		cfg_addr = a;
		cfg_data = v[4:0];
		@(negedge clk);
		cfg_we = 0;
		case (a)
			REG_CP_LEN:   cfg_cp = v;
			REG_ROLLOFF:  cfg_roll = v;
			REG_SYNC_SYM: cfg_sync = v;
			default:      cfg_pkt = v;
		endcase
	endtask

	function automatic void add_row(op_t op, logic [15:0] re, logic [15:0] im, logic eop,
			logic [9:0] idx, logic [15:0] coef, int reps, bit typed, sample_res_t want);
		stim_row_t row;
		row = '{op, re, im, eop, idx, coef, reps, typed, want};
		dir_tab.push_back(row);
	endfunction

	// receiver
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready = 0;
				repeat (300) @(negedge clk);
			end
			m_tready = !(idle_on && $urandom_range(99) < 33);
		end
	end

	// output checker
	always @(posedge clk) begin
		sample_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser[1]};
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected output vld=%0b re=%0d im=%0d last=%0b acc=%0b",
					$time, got.vld, got.re, got.im, got.last, got.acc);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected vld=%0b re=%0d im=%0d last=%0b acc=%0b",
						$time, want.vld, want.re, want.im, want.last, want.acc);
					$display("%0t:          actual vld=%0b re=%0d im=%0d last=%0b acc=%0b",
						$time, got.vld, got.re, got.im, got.last, got.acc);
				end
			end
		end
	end

	// watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		sample_res_t r;
		int done, pick, phase;
		op_t op;
		logic [15:0] re, im, coef;
		logic [9:0] idx;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_data = '0;
		sync_pos = 0; wr_pos = 0; rd_pos = 0; wsel = 0; rsel = 0;
		sym_cp = 0; sym_nwin = 0; flush_idx = 0; flush_len = 0;
		full = 0; flush_pend = 0; flushing = 0;
		foreach (tail_re[i]) begin
			tail_re[i] = 0;
			tail_im[i] = 0;
			ramp[i] = 0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty pull, bad ramp indexes, clamped ramp, extreme samples
		add_row(OP_PULL, 0, 0, 0, 0, 0, 1, 1, '0);
		add_row(OP_RAMP, 0, 0, 0, 10'd15, 16'd100, 1, 1, '0);
		add_row(OP_RAMP, 0, 0, 0, 10'd1023, 16'd100, 1, 1, '0);
		add_row(OP_RAMP, 0, 0, 0, 10'd0, 16'hffff, 1, 1, '{0, 0, 0, 0, 1});
		add_row(OP_SYNC, 16'h8000, 16'h7fff, 0, 10'd1023, 0, 1, 1, '{0, 0, 0, 0, 1});
		add_row(OP_PUSH, 16'h7fff, 16'h8000, 0, 0, 0, FFT_LEN, 0, '0);
		add_row(OP_PUSH, 16'h8000, 16'h7fff, 1, 0, 0, FFT_LEN, 0, '0);
		add_row(OP_PUSH, 16'h1234, 16'h4321, 0, 0, 0, 1, 1, '0);
		add_row(OP_PULL, 0, 0, 0, 0, 0, 2 * (FFT_LEN + 16), 0, '0);
		add_row(OP_PULL, 0, 0, 0, 0, 0, 1, 1, '0);

		// fill both tables so no unwritten entry is ever read
		for (int i = 0; i < MAX_CP - 1; i++) begin
			send_item(OP_RAMP, 0, 0, 0, 10'(i), 16'($urandom_range(32768)), r);
			expected_q.push_back(r);
		end
		for (int i = 0; i < SYNC_DEPTH; i++) begin
			send_item(OP_SYNC, 16'($urandom), 16'($urandom), 0, 10'(i), 0, r);
			expected_q.push_back(r);
		end
		foreach (dir_tab[k]) begin
			for (int n = 0; n < dir_tab[k].reps; n++) begin
				send_item(dir_tab[k].op, dir_tab[k].re, dir_tab[k].im, dir_tab[k].eop,
					dir_tab[k].idx, dir_tab[k].coef, r);
				expected_q.push_back(dir_tab[k].typed ? dir_tab[k].want : r);
			end
		end

		for (phase = 0; phase < 7; phase++) begin
			drain_outputs();
			case (phase)
				0: begin
					write_reg(REG_CP_LEN, 16); write_reg(REG_ROLLOFF, 16);
					write_reg(REG_SYNC_SYM, 12); write_reg(REG_PACKET, 1);
				end
				1: begin
					write_reg(REG_CP_LEN, 0); write_reg(REG_ROLLOFF, 0);
					write_reg(REG_SYNC_SYM, 1); write_reg(REG_PACKET, 0);
				end
				default: begin
					write_reg(REG_CP_LEN, $urandom_range(16));
					write_reg(REG_ROLLOFF, $urandom_range(16));
					write_reg(REG_SYNC_SYM, $urandom_range(12, 1));
					write_reg(REG_PACKET, $urandom_range(1));
				end
			endcase
			idle_on = (phase != 3);
			if (phase == 2) hold_req = 1;
			done = 0;
			while (done < 60) begin
				pick = $urandom_range(99);
				op = (pick < 46) ? OP_PUSH : (pick < 92) ? OP_PULL :
					(pick < 96) ? OP_SYNC : OP_RAMP;
				re = 16'($urandom);
				im = 16'($urandom);
				if ($urandom_range(9) == 0) re = $urandom_range(1) ? 16'h7fff : 16'h8000;
				if ($urandom_range(9) == 0) im = $urandom_range(1) ? 16'h7fff : 16'h8000;
				idx = (op == OP_RAMP) ? 10'($urandom_range(15)) : 10'($urandom);
				coef = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
				send_item(op, re, im, $urandom_range(9) < 3, idx, coef, r);
				expected_q.push_back(r);
				done++;
			end
		end
		idle_on = 1;

		drain_outputs();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
